// ===== rtl/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// vau_pkg
// shared constants for the three-component vector unit: operation and status
// codes, default word format and the normalise datapath sizes
// ----------------------------------------------------------------------------
package vau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SUB   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SCALE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DOT   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CROSS = 3'd4;
	localparam logic [FUNC_W-1:0] FN_NORM  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

	// normalise: radicand scaled by 4^k toward 2^RAD_TOP, k capped at K_MAX
	localparam int K_MAX     = 40;
	localparam int RAD_TOP   = 124;
	localparam int ROOT_BITS = 63;

endpackage

// ===== rtl/vau_in_if.sv =====
// ----------------------------------------------------------------------------
// vau_in_if
// request channel of the vector unit: valid, ready, operation and operands
// ----------------------------------------------------------------------------
interface vau_in_if import vau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) ();
	logic                        valid;
	logic                        ready;
	logic [FUNC_W-1:0]           func;
	logic signed [WORD_BITS-1:0] a_x;
	logic signed [WORD_BITS-1:0] a_y;
	logic signed [WORD_BITS-1:0] a_z;
	logic signed [WORD_BITS-1:0] b_x;
	logic signed [WORD_BITS-1:0] b_y;
	logic signed [WORD_BITS-1:0] b_z;
	logic signed [WORD_BITS-1:0] scale_factor;

	modport source (
		output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		input  ready
	);
	modport sink (
		input  valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
		output ready
	);
endinterface

// ===== rtl/vau_out_if.sv =====
// ----------------------------------------------------------------------------
// vau_out_if
// result channel of the vector unit: valid, ready, result vector and status
// ----------------------------------------------------------------------------
interface vau_out_if import vau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) ();
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] r_x;
	logic signed [WORD_BITS-1:0] r_y;
	logic signed [WORD_BITS-1:0] r_z;
	logic [STATUS_W-1:0]         status;

	modport source (
		output valid, r_x, r_y, r_z, status,
		input  ready
	);
	modport sink (
		input  valid, r_x, r_y, r_z, status,
		output ready
	);
endinterface

// ===== rtl/vector3_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// pipelined fixed-point vector unit: add, subtract, scale, dot, cross and
// normalise with rounding and saturation
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+----------------------------------------
//   req      | in  | valid/ready  | func, a_x..a_z, b_x..b_z, scale_factor
//   rsp      | out | valid/ready  | r_x, r_y, r_z, status
//
// one request per cycle unless the pipeline holds, and the same latency for every op
// the latency is set by the normalise path: 63 square-root digit stages and
// FRAC_BITS+2 restoring divide stages, one bit per stage
// the whole pipeline holds while the output register is full and not taken
// arst_n clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit import vau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	vau_in_if.sink    req,
	vau_out_if.source rsp
);

	localparam int W    = WORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int PW   = 2 * W;
	localparam int TW   = 2 * W + 2;
	localparam int KW   = $clog2(K_MAX + 1);
	localparam int LW   = $clog2(TW);
	localparam int RT   = ROOT_BITS;
	localparam int RB   = 2 * RT;
	localparam int REMW = RT + 3;
	localparam int QB   = F + 2;
	localparam int NB   = W + F + K_MAX;
	localparam int DREM = RT + 1;
	localparam int SHW  = $clog2(F + K_MAX + 1);

	localparam logic signed [TW-1:0] MAXV  = TW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [TW-1:0] MINV  = ~MAXV;
	localparam logic signed [TW-1:0] RHALF = TW'(64'sd1 <<< (F - 1));

	typedef struct packed {
		logic                norm;
		logic                zero;
		logic [2:0]          neg;
		logic [KW-1:0]       k;
		logic [2:0][W-1:0]   mag;
		logic [2:0][W-1:0]   res;
		logic [STATUS_W-1:0] status;
	} pass_t;

	// {saturated, value}
	function automatic logic [W:0] sat_w(input logic signed [TW-1:0] v);
		if (v > MAXV)
			return {1'b1, MAXV[W-1:0]};
		else if (v < MINV)
			return {1'b1, MINV[W-1:0]};
		else
			return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic signed [TW-1:0] rnd(input logic signed [TW-1:0] v);
		return (v + RHALF) >>> F;
	endfunction

	logic adv;

	// stage 1
	logic                v_s1;
	logic [FUNC_W-1:0]   func_s1;
	logic signed [W-1:0] a_s1   [3];
	logic signed [W-1:0] b_s1   [3];
	logic signed [W-1:0] opa_s1 [6];
	logic signed [W-1:0] opb_s1 [6];
	// stage 2
	logic                 v_s2;
	logic [FUNC_W-1:0]    func_s2;
	logic signed [PW-1:0] prod_s2 [6];
	logic signed [W:0]    as_s2   [3];
	logic [W-1:0]         mag_s2  [3];
	logic [2:0]           neg_s2;
	// stage 3
	logic                 v_s3;
	logic [FUNC_W-1:0]    func_s3;
	logic signed [TW-1:0] t_s3   [3];
	logic signed [W:0]    as_s3  [3];
	logic [W-1:0]         mag_s3 [3];
	logic [2:0]           neg_s3;
	// stage 4
	logic          v_s4;
	pass_t         pass_s4;
	logic [TW-1:0] sq_s4;
	// square-root stages, index 0 is the scaling stage
	logic            sq_v_s    [0:RT];
	pass_t           sq_pass_s [0:RT];
	logic [RB-1:0]   sq_rad_s  [0:RT];
	logic [REMW-1:0] sq_rem_s  [0:RT];
	logic [RT-1:0]   sq_root_s [0:RT];
	logic [RB-1:0]   sq_rad_n  [1:RT];
	logic [REMW-1:0] sq_rem_n  [1:RT];
	logic [RT-1:0]   sq_root_n [1:RT];
	// divide stages, index 0 is the numerator set-up stage
	logic            dv_v_s    [0:QB];
	pass_t           dv_pass_s [0:QB];
	logic [RT-1:0]   dv_d_s    [0:QB];
	logic [DREM-1:0] dv_rem_s  [0:QB][3];
	logic [QB-1:0]   dv_nlo_s  [0:QB][3];
	logic [QB-1:0]   dv_q_s    [0:QB][3];
	logic [DREM-1:0] dv_rem_n  [1:QB][3];
	logic [QB-1:0]   dv_nlo_n  [1:QB][3];
	logic [QB-1:0]   dv_q_n    [1:QB][3];
	logic [DREM-1:0] dv_rem0   [3];
	logic [QB-1:0]   dv_nlo0   [3];
	// output register
	logic                o_v_q;
	logic [2:0][W-1:0]   o_res_q;
	logic [STATUS_W-1:0] o_st_q;

	logic signed [W-1:0] va [3];
	logic signed [W-1:0] vb [3];
	logic signed [W-1:0] ma [6];
	logic signed [W-1:0] mb [6];
	logic signed [TW-1:0] t_n [3];
	pass_t         p4;
	logic [TW-1:0] sq4;
	logic [2:0][W-1:0]   f_res;
	logic [STATUS_W-1:0] f_st;

	assign adv       = !o_v_q || rsp.ready;
	assign req.ready = adv;

	// operand selection for the six multipliers
	always_comb begin
		va[0] = req.a_x;
		va[1] = req.a_y;
		va[2] = req.a_z;
		vb[0] = req.b_x;
		vb[1] = req.b_y;
		vb[2] = req.b_z;
		for (int i = 0; i < 6; i++) begin
			ma[i] = '0;
			mb[i] = '0;
		end
		case (req.func)
			FN_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = va[i];
					mb[i] = req.scale_factor;
				end
			end
			FN_DOT: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = va[i];
					mb[i] = vb[i];
				end
			end
			FN_NORM: begin
				for (int i = 0; i < 3; i++) begin
					ma[i] = va[i];
					mb[i] = va[i];
				end
			end
			FN_CROSS: begin
				ma[0] = va[1]; mb[0] = vb[2];
				ma[1] = va[2]; mb[1] = vb[1];
				ma[2] = va[2]; mb[2] = vb[0];
				ma[3] = va[0]; mb[3] = vb[2];
				ma[4] = va[0]; mb[4] = vb[1];
				ma[5] = va[1]; mb[5] = vb[0];
			end
			default: ;
		endcase
	end

	// sums and differences of products
	always_comb begin
		for (int i = 0; i < 3; i++)
			t_n[i] = '0;
		case (func_s2) inside
			FN_SCALE: begin
				for (int i = 0; i < 3; i++)
					t_n[i] = TW'(prod_s2[i]);
			end
			FN_DOT, FN_NORM: begin
				t_n[0] = TW'(prod_s2[0]) + TW'(prod_s2[1]) + TW'(prod_s2[2]);
			end
			FN_CROSS: begin
				t_n[0] = TW'(prod_s2[0]) - TW'(prod_s2[1]);
				t_n[1] = TW'(prod_s2[2]) - TW'(prod_s2[3]);
				t_n[2] = TW'(prod_s2[4]) - TW'(prod_s2[5]);
			end
			default: ;
		endcase
	end

	// rounding, saturation and normalise shift count
	always_comb begin
		logic [W:0]    sr;
		logic          flag;
		logic [LW-1:0] msb;
		logic [7:0]    kt;
		p4       = '0;
		flag     = 1'b0;
		sr       = '0;
		msb      = '0;
		p4.neg   = neg_s3;
		for (int i = 0; i < 3; i++)
			p4.mag[i] = mag_s3[i];
		case (func_s3) inside
			FN_ADD, FN_SUB: begin
				for (int i = 0; i < 3; i++) begin
					sr        = sat_w(TW'(as_s3[i]));
					p4.res[i] = sr[W-1:0];
					flag      = flag | sr[W];
				end
			end
			FN_SCALE, FN_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					sr        = sat_w(rnd(t_s3[i]));
					p4.res[i] = sr[W-1:0];
					flag      = flag | sr[W];
				end
			end
			FN_DOT: begin
				sr        = sat_w(rnd(t_s3[0]));
				p4.res[0] = sr[W-1:0];
				flag      = sr[W];
			end
			FN_NORM: p4.norm = 1'b1;
			default: ;
		endcase
		p4.status = flag ? ST_SAT : ST_OK;
		sq4       = t_s3[0];
		p4.zero   = (sq4 == '0);
		for (int i = 0; i < TW; i++)
			if (sq4[i])
				msb = LW'(i);
		kt = (8'(RAD_TOP + 1) - 8'(msb)) >> 1;
		if (kt > 8'(K_MAX))
			kt = 8'(K_MAX);
		p4.k = KW'(kt);
	end

	// square-root digit recurrence, one root bit per stage
	always_comb begin
		logic [REMW-1:0] cur;
		logic [REMW-1:0] trial;
		for (int j = 1; j <= RT; j++) begin
			cur   = {sq_rem_s[j-1][REMW-3:0], sq_rad_s[j-1][RB-1 -: 2]};
			trial = {1'b0, sq_root_s[j-1], 2'b01};
			if (cur >= trial) begin
				sq_rem_n[j]  = cur - trial;
				sq_root_n[j] = {sq_root_s[j-1][RT-2:0], 1'b1};
			end else begin
				sq_rem_n[j]  = cur;
				sq_root_n[j] = {sq_root_s[j-1][RT-2:0], 1'b0};
			end
			sq_rad_n[j] = sq_rad_s[j-1] << 2;
		end
	end

	// numerator set-up: |a| scaled by 2^(F+k), split into head and low bits
	always_comb begin
		logic [SHW-1:0] nsh;
		logic [NB-1:0]  num;
		nsh = SHW'(F) + SHW'(sq_pass_s[RT].k);
		num = '0;
		for (int c = 0; c < 3; c++) begin
			num        = NB'(sq_pass_s[RT].mag[c]) << nsh;
			dv_rem0[c] = DREM'(num >> QB);
			dv_nlo0[c] = num[QB-1:0];
		end
	end

	// restoring divide, one quotient bit per stage
	always_comb begin
		logic [DREM:0] cur;
		logic [DREM:0] dext;
		for (int j = 1; j <= QB; j++) begin
			dext = (DREM + 1)'(dv_d_s[j-1]);
			for (int c = 0; c < 3; c++) begin
				cur = {dv_rem_s[j-1][c], dv_nlo_s[j-1][c][QB-1]};
				if (cur >= dext) begin
					dv_rem_n[j][c] = DREM'(cur - dext);
					dv_q_n[j][c]   = {dv_q_s[j-1][c][QB-2:0], 1'b1};
				end else begin
					dv_rem_n[j][c] = DREM'(cur);
					dv_q_n[j][c]   = {dv_q_s[j-1][c][QB-2:0], 1'b0};
				end
				dv_nlo_n[j][c] = dv_nlo_s[j-1][c] << 1;
			end
		end
	end

	// final sign, saturation and result select
	always_comb begin
		logic signed [TW-1:0] nv;
		logic [W:0]           sr;
		logic                 flag;
		flag  = 1'b0;
		nv    = '0;
		sr    = '0;
		f_res = dv_pass_s[QB].res;
		f_st  = dv_pass_s[QB].status;
		if (dv_pass_s[QB].norm) begin
			if (dv_pass_s[QB].zero) begin
				f_res = '0;
				f_st  = ST_ZERO;
			end else begin
				for (int c = 0; c < 3; c++) begin
					nv = TW'(dv_q_s[QB][c]);
					if (dv_pass_s[QB].neg[c])
						nv = -nv;
					sr       = sat_w(nv);
					f_res[c] = sr[W-1:0];
					flag     = flag | sr[W];
				end
				f_st = flag ? ST_SAT : ST_OK;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			o_v_q <= 1'b0;
			for (int j = 0; j <= RT; j++)
				sq_v_s[j] <= 1'b0;
			for (int j = 0; j <= QB; j++)
				dv_v_s[j] <= 1'b0;
		end else if (adv) begin
			v_s1      <= req.valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			sq_v_s[0] <= v_s4;
			for (int j = 1; j <= RT; j++)
				sq_v_s[j] <= sq_v_s[j-1];
			dv_v_s[0] <= sq_v_s[RT];
			for (int j = 1; j <= QB; j++)
				dv_v_s[j] <= dv_v_s[j-1];
			o_v_q <= dv_v_s[QB];
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= req.func;
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= va[i];
				b_s1[i] <= vb[i];
			end
			for (int i = 0; i < 6; i++) begin
				opa_s1[i] <= ma[i];
				opb_s1[i] <= mb[i];
			end

			func_s2 <= func_s1;
			for (int i = 0; i < 6; i++)
				prod_s2[i] <= PW'(opa_s1[i]) * PW'(opb_s1[i]);
			for (int i = 0; i < 3; i++) begin
				as_s2[i]  <= (func_s1 == FN_SUB) ? ((W + 1)'(a_s1[i]) - (W + 1)'(b_s1[i]))
				                                 : ((W + 1)'(a_s1[i]) + (W + 1)'(b_s1[i]));
				mag_s2[i] <= a_s1[i][W-1] ? W'(-a_s1[i]) : W'(a_s1[i]);
				neg_s2[i] <= a_s1[i][W-1];
			end

			func_s3 <= func_s2;
			neg_s3  <= neg_s2;
			for (int i = 0; i < 3; i++) begin
				t_s3[i]   <= t_n[i];
				as_s3[i]  <= as_s2[i];
				mag_s3[i] <= mag_s2[i];
			end

			pass_s4 <= p4;
			sq_s4   <= sq4;

			sq_pass_s[0] <= pass_s4;
			sq_rad_s[0]  <= RB'(sq_s4) << {pass_s4.k, 1'b0};
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			for (int j = 1; j <= RT; j++) begin
				sq_pass_s[j] <= sq_pass_s[j-1];
				sq_rad_s[j]  <= sq_rad_n[j];
				sq_rem_s[j]  <= sq_rem_n[j];
				sq_root_s[j] <= sq_root_n[j];
			end

			dv_pass_s[0] <= sq_pass_s[RT];
			dv_d_s[0]    <= sq_root_s[RT];
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= dv_rem0[c];
				dv_nlo_s[0][c] <= dv_nlo0[c];
				dv_q_s[0][c]   <= '0;
			end
			for (int j = 1; j <= QB; j++) begin
				dv_pass_s[j] <= dv_pass_s[j-1];
				dv_d_s[j]    <= dv_d_s[j-1];
				for (int c = 0; c < 3; c++) begin
					dv_rem_s[j][c] <= dv_rem_n[j][c];
					dv_nlo_s[j][c] <= dv_nlo_n[j][c];
					dv_q_s[j][c]   <= dv_q_n[j][c];
				end
			end

			o_res_q <= f_res;
			o_st_q  <= f_st;
		end
	end

	assign rsp.valid  = o_v_q;
	assign rsp.r_x    = o_res_q[0];
	assign rsp.r_y    = o_res_q[1];
	assign rsp.r_z    = o_res_q[2];
	assign rsp.status = o_st_q;

endmodule
